// ===== sv/page_table_mapper_macros.svh =====
// Assertion macros of the page table mapper RTL.
`ifndef PAGE_TABLE_MAPPER_MACROS_SVH
`define PAGE_TABLE_MAPPER_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define PTM_ASSERT_IMP(name, ante, cons) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("page table mapper check failed");

// Next-cycle implication, checked outside reset.
`define PTM_ASSERT_NXT(name, ante, cons) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("page table mapper check failed");

`endif

// ===== sv/ptm_pkg.sv =====
// Package with constants and types of the page table mapper.
`default_nettype none
package ptm_pkg;

    localparam int TABLE_PAGES      = 64;
    localparam int ENTRIES_PER_PAGE = 512;
    localparam int IDX_W            = $clog2(ENTRIES_PER_PAGE);
    localparam int PAGE_W           = $clog2(TABLE_PAGES);
    localparam int SCAN_W           = $clog2(TABLE_PAGES + 1);
    localparam int PG_SEL_W         = $clog2(TABLE_PAGES + 2);
    localparam int MEM_DEPTH        = (TABLE_PAGES + 2) * ENTRIES_PER_PAGE;
    localparam int MEM_ADDR_W       = PG_SEL_W + IDX_W;

    typedef enum logic [1:0] {
        OP_MAP  = 2'd0,
        OP_CTX  = 2'd1,
        OP_FREE = 2'd2,
        OP_NONE = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_ALIGN   = 2'd1,
        ST_HUGE    = 2'd2,
        ST_BADFREE = 2'd3
    } t_status;

    // Requests from the sequencer to the free page bitmap.
    typedef struct packed {
        logic              free_all;
        logic              scan;
        logic              release_pg;
        logic [PAGE_W-1:0] rel_page;
    } t_fm_ctl;

    // Answer of the bitmap scan.
    typedef struct packed {
        logic              done;
        logic              found;
        logic [PAGE_W-1:0] page;
    } t_fm_stat;

endpackage
`default_nettype wire

// ===== sv/page_table_mapper.sv =====
// Top level of the four-level page table mapper: sequencer and table store.
//
// Channel   Direction  Beat contents
// s_axis    in         tuser: opcode; tdata: phys, virt, span, flags, freed page
// m_axis    out        tuser: status; tdata: mapped_size
// cfg       in         table_base (page aligned, low 12 bits ignored)
//
// A map beat on existing tables runs through one dispatch state, a read and an evaluate
// state for each of the three upper levels on the single table store port, one
// read-and-write state at the leaf level and one result state.
// Each table that has to be built adds a bitmap scan, a clear of every entry of the
// new page and a link step that writes the pointer into the parent table.
// Reset context clears two entries of the new root page; free and unknown ops write none.
// After reset the two root pages are cleared before any beat is taken.
// A finished result waits in the output register; the next beat is taken meanwhile.
`default_nettype none
module page_table_mapper (
    input  wire          i_clk,
    input  wire          i_rst_n,
    input  wire          i_s_tvalid,
    output logic         o_s_tready,
    // phys_addr[49:0], virt_addr[97:50], span[161:98], entry_flags[225:162],
    // freed_page_addr[275:226], zero fill [279:276]
    input  wire  [279:0] i_s_tdata,
    // opcode[1:0]
    input  wire  [1:0]   i_s_tuser,
    output logic         o_m_tvalid,
    input  wire          i_m_tready,
    // mapped_size[39:0]
    output logic [39:0]  o_m_tdata,
    // status[1:0]
    output logic [1:0]   o_m_tuser,
    input  wire          i_cfg_valid,
    output logic         o_cfg_ready,
    input  wire  [49:0]  i_cfg_data
);

    typedef enum logic [3:0] {
        S_INIT, S_IDLE, S_DISP, S_RD, S_EVAL, S_SCAN, S_CLEAR, S_LINK,
        S_CTX0, S_CTX1, S_DONE
    } t_state;

    localparam int PGW = ptm_pkg::PG_SEL_W;

    t_state                     r_state;
    ptm_pkg::t_op               r_op;
    logic [49:0]                r_phys;
    logic [47:0]                r_virt;
    logic [63:0]                r_span;
    logic [63:0]                r_flags;
    logic [49:0]                r_freed;
    logic [37:0]                r_base_pg;
    logic                       r_root;
    logic [1:0]                 r_lvl;
    logic [PGW-1:0]             r_page;
    logic [ptm_pkg::PAGE_W-1:0] r_np;
    logic [ptm_pkg::IDX_W:0]    r_cnt;
    logic [39:0]                r_res_size;
    ptm_pkg::t_status           r_res_st;
    logic                       r_out_valid;
    logic [39:0]                r_out_size;
    ptm_pkg::t_status           r_out_st;
    logic [63:0]                r_rd_data;

    // The table store: dynamic pages first, then the two root pages.
    logic [63:0] r_mem [ptm_pkg::MEM_DEPTH];

    logic                       w_we;
    logic [ptm_pkg::MEM_ADDR_W-1:0] w_wa;
    logic [63:0]                w_wd;
    logic [ptm_pkg::IDX_W-1:0]  w_idx;
    logic [ptm_pkg::MEM_ADDR_W-1:0] w_walk_addr;
    logic [PGW-1:0]             w_root_pg;
    logic                       w_leaf_ok;
    logic [39:0]                w_region;
    logic [37:0]                w_tdiff;
    logic                       w_ptr_ok;
    logic                       w_huge_root;
    logic                       w_absent;
    logic                       w_alloc;
    logic [37:0]                w_fdiff;
    logic                       w_free_ok;
    logic                       w_bad_args;
    ptm_pkg::t_fm_ctl           w_fm_ctl;
    ptm_pkg::t_fm_stat          w_fm_stat;

    assign o_s_tready  = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_m_tvalid  = r_out_valid;
    assign o_m_tdata   = r_out_size;
    assign o_m_tuser   = r_out_st;

    assign w_root_pg   = PGW'(ptm_pkg::TABLE_PAGES) + PGW'(r_root);
    assign w_walk_addr = {r_page, w_idx};

    // Index bits of the current level and the leaf test of that level.
    always_comb begin
        w_idx     = r_virt[20:12];
        w_leaf_ok = 1'b0;
        w_region  = 40'h00_0000_1000;
        case (r_lvl)
            2'd0: begin
                w_idx    = r_virt[47:39];
                w_region = 40'h80_0000_0000;
            end
            2'd1: begin
                w_idx     = r_virt[38:30];
                w_region  = 40'h00_4000_0000;
                w_leaf_ok = (r_phys[29:0] == '0) && (r_virt[29:0] == '0)
                            && (r_span >= 64'h4000_0000);
            end
            2'd2: begin
                w_idx     = r_virt[29:21];
                w_region  = 40'h00_0020_0000;
                w_leaf_ok = (r_phys[20:0] == '0) && (r_virt[20:0] == '0)
                            && (r_span >= 64'h20_0000);
            end
            default: begin
                w_idx = r_virt[20:12];
            end
        endcase
    end

    // An entry is a usable pointer only if it lands inside the dynamic pages.
    assign w_tdiff     = r_rd_data[49:12] - r_base_pg;
    assign w_ptr_ok    = r_rd_data[0] && !r_rd_data[7]
                         && (w_tdiff < 38'(ptm_pkg::TABLE_PAGES));
    assign w_huge_root = (r_lvl == 2'd0) && r_rd_data[0] && r_rd_data[7];
    assign w_absent    = !r_rd_data[0] && !r_flags[0];
    assign w_alloc     = (r_state == S_EVAL) && !w_huge_root && !w_leaf_ok
                         && !w_ptr_ok && !w_absent;

    assign w_fdiff    = r_freed[49:12] - r_base_pg;
    assign w_free_ok  = (r_freed[11:0] == '0) && (w_fdiff < 38'(ptm_pkg::TABLE_PAGES));
    assign w_bad_args = (r_phys[11:0] != '0) || (r_virt[11:0] != '0)
                        || (r_span[11:0] != '0) || (r_span == '0);

    always_comb begin
        w_fm_ctl.free_all   = (r_state == S_DISP) && (r_op == ptm_pkg::OP_CTX);
        w_fm_ctl.scan       = w_alloc;
        w_fm_ctl.release_pg = (r_state == S_DISP) && (r_op == ptm_pkg::OP_FREE) && w_free_ok;
        w_fm_ctl.rel_page   = w_fdiff[ptm_pkg::PAGE_W-1:0];
    end

    ptm_free_map u_free_map (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_fm_ctl),
        .o_stat  (w_fm_stat)
    );

    // Single write port of the table store.
    always_comb begin
        w_we = 1'b0;
        w_wa = w_walk_addr;
        w_wd = '0;
        case (r_state)
            S_INIT: begin
                w_we = 1'b1;
                w_wa = {PGW'(ptm_pkg::TABLE_PAGES) + PGW'(r_cnt[ptm_pkg::IDX_W]),
                        r_cnt[ptm_pkg::IDX_W-1:0]};
            end
            S_RD: begin
                if (r_lvl == 2'd3) begin
                    w_we = 1'b1;
                    w_wd = {14'd0, r_phys} | r_flags;
                end
            end
            S_EVAL: begin
                if (!w_huge_root && r_lvl != 2'd0 && w_leaf_ok) begin
                    w_we = 1'b1;
                    w_wd = {14'd0, r_phys} | 64'h80 | r_flags;
                end
            end
            S_CLEAR: begin
                w_we = 1'b1;
                w_wa = {PGW'(r_np), r_cnt[ptm_pkg::IDX_W-1:0]};
            end
            S_LINK: begin
                w_we = 1'b1;
                w_wd = {14'd0, r_base_pg + 38'(r_np), 12'h007};
            end
            S_CTX0: begin
                w_we = 1'b1;
                w_wa = {w_root_pg, ptm_pkg::IDX_W'(0)};
            end
            S_CTX1: begin
                w_we = 1'b1;
                w_wa = {w_root_pg, ptm_pkg::IDX_W'(ptm_pkg::ENTRIES_PER_PAGE - 1)};
            end
            default: begin
                w_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_wa] <= w_wd;
        end
        r_rd_data <= r_mem[w_walk_addr];
    end

    // Sequencer with its registered result.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_INIT;
            r_root      <= 1'b0;
            r_base_pg   <= '0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
            r_lvl       <= '0;
        end else begin
            if (i_cfg_valid) begin
                r_base_pg <= i_cfg_data[49:12];
            end
            if (r_out_valid && i_m_tready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_INIT: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == '1) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (i_s_tvalid) begin
                        r_op    <= ptm_pkg::t_op'(i_s_tuser);
                        r_phys  <= i_s_tdata[49:0];
                        r_virt  <= i_s_tdata[97:50];
                        r_span  <= i_s_tdata[161:98];
                        r_flags <= i_s_tdata[225:162];
                        r_freed <= i_s_tdata[275:226];
                        r_state <= S_DISP;
                    end
                end
                S_DISP: begin
                    r_res_size <= '0;
                    r_res_st   <= ptm_pkg::ST_OK;
                    r_state    <= S_DONE;
                    case (r_op)
                        ptm_pkg::OP_MAP: begin
                            if (w_bad_args) begin
                                r_res_st <= ptm_pkg::ST_ALIGN;
                            end else begin
                                r_page  <= w_root_pg;
                                r_lvl   <= 2'd0;
                                r_state <= S_RD;
                            end
                        end
                        ptm_pkg::OP_CTX: begin
                            r_root  <= ~r_root;
                            r_state <= S_CTX0;
                        end
                        ptm_pkg::OP_FREE: begin
                            if (!w_free_ok) begin
                                r_res_st <= ptm_pkg::ST_BADFREE;
                            end
                        end
                        default: begin
                            r_res_st <= ptm_pkg::ST_OK;
                        end
                    endcase
                end
                S_RD: begin
                    if (r_lvl == 2'd3) begin
                        r_res_size <= 40'h00_0000_1000;
                        r_state    <= S_DONE;
                    end else begin
                        r_state <= S_EVAL;
                    end
                end
                S_EVAL: begin
                    if (w_huge_root) begin
                        r_res_st <= ptm_pkg::ST_HUGE;
                        r_state  <= S_DONE;
                    end else if (w_leaf_ok) begin
                        r_res_size <= w_region;
                        r_state    <= S_DONE;
                    end else if (w_ptr_ok) begin
                        r_page  <= PGW'(w_tdiff[ptm_pkg::PAGE_W-1:0]);
                        r_lvl   <= r_lvl + 1'b1;
                        r_state <= S_RD;
                    end else if (w_absent) begin
                        r_res_size <= w_region;
                        r_state    <= S_DONE;
                    end else begin
                        r_state <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (w_fm_stat.done) begin
                        if (w_fm_stat.found) begin
                            r_np    <= w_fm_stat.page;
                            r_cnt   <= '0;
                            r_state <= S_CLEAR;
                        end else begin
                            r_state <= S_DONE;
                        end
                    end
                end
                S_CLEAR: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt[ptm_pkg::IDX_W-1:0] == '1) begin
                        r_state <= S_LINK;
                    end
                end
                S_LINK: begin
                    r_page  <= PGW'(r_np);
                    r_lvl   <= r_lvl + 1'b1;
                    r_state <= S_RD;
                end
                S_CTX0: begin
                    r_state <= S_CTX1;
                end
                S_CTX1: begin
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (!r_out_valid || i_m_tready) begin
                        r_out_valid <= 1'b1;
                        r_out_size  <= r_res_size;
                        r_out_st    <= r_res_st;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

`include "page_table_mapper_macros.svh"

    // A taken beat always starts a dispatch.
    `PTM_ASSERT_NXT(a_accept_disp, i_s_tvalid && o_s_tready, r_state == S_DISP)
    // The leaf level is only reached through a dynamic page.
    `PTM_ASSERT_IMP(a_leaf_dyn, r_state == S_RD && r_lvl == 2'd3, r_page < PGW'(ptm_pkg::TABLE_PAGES))
    // Nothing writes the table store while the block waits for a beat.
    `PTM_ASSERT_IMP(a_idle_nowrite, r_state == S_IDLE || r_state == S_DONE, !w_we)
    // A scan is only started when no scan is already answering.
    `PTM_ASSERT_IMP(a_scan_single, w_fm_ctl.scan, !w_fm_stat.done)

endmodule
`default_nettype wire

// ===== sv/ptm_free_map.sv =====
// Free page bitmap with a lowest-first allocation scan, one bit per cycle.
`default_nettype none
module ptm_free_map (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  ptm_pkg::t_fm_ctl  i_ctl,
    output ptm_pkg::t_fm_stat o_stat
);

    logic [ptm_pkg::TABLE_PAGES-1:0] r_map;
    logic                            r_busy;
    logic [ptm_pkg::SCAN_W-1:0]      r_cnt;
    logic                            w_end;
    logic                            w_hit;

    assign w_end = (r_cnt == ptm_pkg::SCAN_W'(ptm_pkg::TABLE_PAGES));
    assign w_hit = !w_end && r_map[r_cnt[ptm_pkg::PAGE_W-1:0]];

    assign o_stat.done  = r_busy && (w_end || w_hit);
    assign o_stat.found = r_busy && w_hit;
    assign o_stat.page  = r_cnt[ptm_pkg::PAGE_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_map  <= '1;
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else begin
            if (i_ctl.free_all) begin
                r_map <= '1;
            end else if (i_ctl.release_pg) begin
                r_map[i_ctl.rel_page] <= 1'b1;
            end else if (r_busy && w_hit) begin
                r_map[r_cnt[ptm_pkg::PAGE_W-1:0]] <= 1'b0;
            end
            if (i_ctl.scan) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                if (w_end || w_hit) begin
                    r_busy <= 1'b0;
                end else begin
                    r_cnt <= r_cnt + 1'b1;
                end
            end
        end
    end

endmodule
`default_nettype wire
